// File: rtl/sbld_pkg.sv
package sbld_pkg;

    // Default length limit of one label, in characters.
    localparam int MAX_CHARS_DEF = 1023;
    // Depth of the code queue between the front and the back. A power of two.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_SEP  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Table selectors.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_PUNCT  = 2'd1;
    localparam logic [1:0] MODE_LOWER  = 2'd2;

    // Special codes of the normal table.
    localparam logic [5:0] CODE_LOWER_SHIFT = 6'h1B;
    localparam logic [5:0] CODE_PUNCT_SHIFT = 6'h1C;
    localparam logic [5:0] CODE_SEP_LO      = 6'h1D;
    localparam logic [5:0] CODE_SEP_HI      = 6'h1F;
    localparam logic [5:0] CODE_BASE_MAX    = 6'h2F;

    // One queue entry holds the codes completed by one input byte.
    typedef struct packed {
        logic       start;
        logic       two;
        logic [5:0] code_a;
        logic [5:0] code_b;
    } t_entry;

    // Outcome of decoding one code against the current table selector.
    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [6:0] ch;
        logic       char_add;
        logic       sep;
        logic       fin;
        logic [1:0] new_mode;
    } t_dec;

    function automatic logic [6:0] base_char(input logic [5:0] code);
        logic [6:0] c;
        c = 7'd0;
        if (code == 6'd0) begin
            c = 7'h20;
        end else if (code <= 6'd26) begin
            c = 7'h40 + {1'b0, code};
        end else if (code >= 6'd32 && code <= 6'd41) begin
            c = {1'b0, code} + 7'd16;
        end
        return c;
    endfunction

    function automatic logic [6:0] punct_char(input logic [5:0] code);
        logic [6:0] c;
        c = 7'd0;
        if (code == 6'd0) begin
            c = 7'h40;
        end else if (code <= 6'd15) begin
            c = 7'h20 + {1'b0, code};
        end else if (code >= 6'd26 && code <= 6'd31) begin
            c = {1'b0, code} + 7'd32;
        end else if (code >= 6'd43 && code <= 6'd47) begin
            c = {1'b0, code} + 7'd48;
        end
        return c;
    endfunction

    function automatic logic [6:0] lower_char(input logic [5:0] code);
        logic [6:0] c;
        c = 7'd0;
        if (code <= 6'd26) begin
            c = 7'h60 + {1'b0, code};
        end
        return c;
    endfunction

    // Decodes one code. len_full is high when the label has reached its limit.
    function automatic t_dec decode_code(input logic [1:0] mode, input logic len_full,
                                         input logic [5:0] code);
        t_dec d;
        logic [6:0] bc;
        d = '0;
        d.new_mode = MODE_NORMAL;
        bc = base_char(code);
        if (mode == MODE_PUNCT) begin
            d.emit = 1'b1;
            d.kind = KIND_CHAR;
            d.ch = punct_char(code);
            d.char_add = 1'b1;
        end else if (mode == MODE_LOWER) begin
            d.emit = 1'b1;
            d.kind = KIND_CHAR;
            d.ch = lower_char(code);
            d.char_add = 1'b1;
        end else if (len_full || code > CODE_BASE_MAX) begin
            d.emit = 1'b1;
            d.kind = KIND_END;
            d.fin = 1'b1;
        end else if (bc != 7'd0) begin
            d.emit = 1'b1;
            d.kind = KIND_CHAR;
            d.ch = bc;
            d.char_add = 1'b1;
        end else if (code == CODE_PUNCT_SHIFT) begin
            d.new_mode = MODE_PUNCT;
        end else if (code == CODE_LOWER_SHIFT) begin
            d.new_mode = MODE_LOWER;
        end else if (code >= CODE_SEP_LO && code <= CODE_SEP_HI) begin
            d.emit = 1'b1;
            d.kind = KIND_SEP;
            d.sep = 1'b1;
        end
        return d;
    endfunction

endpackage

// File: rtl/sbld_in_if.sv
interface sbld_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] data_byte;

    modport source (output valid, output start_req, output data_byte, input ready);
    modport sink (input valid, input start_req, input data_byte, output ready);
endinterface

// File: rtl/sbld_out_if.sv
interface sbld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [6:0] char_code;
    logic       label_valid;
    logic       last;

    modport source (output valid, output kind, output char_code, output label_valid,
                    output last, input ready);
    modport sink (input valid, input kind, input char_code, input label_valid,
                  input last, output ready);
endinterface

// File: rtl/sbld_front.sv
module sbld_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbld_in_if.sink           i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output sbld_pkg::t_entry  o_entry
);

    // Leftover bits of the previous bytes, right aligned, and their count (0, 2 or 4).
    logic [4:0]  r_store, n_store;
    logic [2:0]  r_count, n_count;
    logic [4:0]  s_store;
    logic [2:0]  s_count;
    logic [12:0] s_comb;
    logic [2:0]  s_shift_a;
    logic        s_two;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        s_store   = i_in.start_req ? 5'd0 : r_store;
        s_count   = i_in.start_req ? 3'd0 : r_count;
        s_comb    = {s_store, i_in.data_byte};
        s_shift_a = s_count + 3'd2;
        s_two     = (s_count >= 3'd4);

        o_entry.start  = i_in.start_req;
        o_entry.two    = s_two;
        o_entry.code_a = 6'(s_comb >> s_shift_a);
        o_entry.code_b = 6'(s_comb >> s_count[0]);

        n_store = s_comb[4:0];
        n_count = s_two ? (s_count - 3'd4) : s_shift_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_store <= n_store;
        end
    end

endmodule

// File: rtl/sbld_fifo.sv
module sbld_fifo #(
    parameter int DEPTH = sbld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sbld_pkg::t_entry  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output sbld_pkg::t_entry  o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sbld_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [PW:0]      r_cnt, n_cnt;
    logic             s_push;
    logic             s_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (s_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (s_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (s_push && !s_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (s_pop && !s_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/sbld_back.sv
module sbld_back #(
    parameter int MAX_CHARS = sbld_pkg::MAX_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  sbld_pkg::t_entry  i_q_entry,
    output logic              o_q_pop,
    sbld_out_if.source        o_out
);

    // The label length saturates at the limit; only "zero", "one below limit" and "at limit" matter.
    localparam int         LW   = $clog2(MAX_CHARS + 1);
    localparam logic [LW-1:0] MAXL = LW'(MAX_CHARS);
    localparam logic [LW-1:0] MAXM = LW'(MAX_CHARS - 1);

    logic [1:0]    r_mode, n_mode;
    logic [LW-1:0] r_len, n_len;
    logic          r_fnz, n_fnz;
    logic          r_fin, n_fin;
    logic          r_phase, n_phase;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_kind;
    logic [6:0]    r_char;
    logic          r_lvalid;
    logic          r_last;

    logic          s_drop, s_work, s_rst;
    logic [1:0]    s_mode;
    logic [LW-1:0] s_len;
    logic          s_fnz;
    logic [5:0]    s_code;
    logic          s_full_after;
    logic          s_more;
    logic          s_last;
    sbld_pkg::t_dec s_dec, s_dec_b;

    always_comb begin
        s_rst  = !r_phase && i_q_entry.start;
        s_drop = i_q_valid && r_fin && !i_q_entry.start;
        s_work = i_q_valid && !s_drop && (!r_out_valid || o_out.ready);

        s_mode = s_rst ? sbld_pkg::MODE_NORMAL : r_mode;
        s_len  = s_rst ? '0 : r_len;
        s_fnz  = s_rst ? 1'b0 : r_fnz;
        s_code = r_phase ? i_q_entry.code_b : i_q_entry.code_a;

        s_dec = sbld_pkg::decode_code(s_mode, s_len >= MAXL, s_code);

        // Look ahead at the second code of the byte to tell whether this result is last.
        if (s_dec.sep) begin
            s_full_after = 1'b0;
        end else if (s_dec.char_add) begin
            s_full_after = (s_len >= MAXM);
        end else begin
            s_full_after = (s_len >= MAXL);
        end
        s_dec_b = sbld_pkg::decode_code(s_dec.new_mode, s_full_after, i_q_entry.code_b);
        s_more  = !r_phase && i_q_entry.two && !s_dec.fin;
        s_last  = !(s_more && s_dec_b.emit);

        n_mode  = r_mode;
        n_len   = r_len;
        n_fnz   = r_fnz;
        n_fin   = r_fin;
        n_phase = r_phase;
        if (s_work) begin
            n_mode  = s_dec.new_mode;
            n_fin   = s_dec.fin;
            n_phase = s_more;
            n_len   = s_len;
            n_fnz   = s_fnz;
            if (s_dec.sep) begin
                n_len = '0;
                n_fnz = 1'b0;
            end else if (s_dec.char_add) begin
                n_len = (s_len == MAXL) ? s_len : s_len + 1'b1;
                if (s_len == '0) begin
                    n_fnz = (s_dec.ch != 7'd0);
                end
            end
        end

        o_q_pop     = s_drop || (s_work && !s_more);
        n_out_valid = (r_out_valid && !o_out.ready) || (s_work && s_dec.emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= sbld_pkg::MODE_NORMAL;
            r_len       <= '0;
            r_fnz       <= 1'b0;
            r_fin       <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_len       <= n_len;
            r_fnz       <= n_fnz;
            r_fin       <= n_fin;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_work && s_dec.emit) begin
            r_kind   <= s_dec.kind;
            r_char   <= s_dec.ch;
            r_lvalid <= (s_dec.kind != sbld_pkg::KIND_CHAR) && (s_len != '0) && s_fnz;
            r_last   <= s_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_kind;
    assign o_out.char_code   = r_char;
    assign o_out.label_valid = r_lvalid;
    assign o_out.last        = r_last;

endmodule

// File: rtl/six_bit_label_decoder.sv
// Decoder for text packed as 6-bit codes, most significant bit first, one byte per item.
// Each input item carries one byte and a start flag that clears all decoding state
// before the byte is used. Every completed code yields at most one result item: a
// character (kind 0), a label separator (kind 1) or the end of the string (kind 2),
// and the final result caused by a byte carries last. Bytes after an end of string
// give no results until the next start. The front takes one byte per cycle into a
// short queue while it has room; the back decodes one 6-bit code per cycle while
// its output register is empty or being taken, and works on a byte once for each
// code it completes (one or two). A steady byte stream carries four codes per three
// bytes. With the queue empty and the output free, a byte's entry is registered in
// the queue, and the result of its first code then in the output register.
module six_bit_label_decoder #(
    parameter int MAX_CHARS   = sbld_pkg::MAX_CHARS_DEF,
    parameter int QUEUE_DEPTH = sbld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbld_in_if.sink     i_in,
    sbld_out_if.source  o_out
);

    // Queue traffic between the byte splitter and the code decoder.
    logic             s_push;
    logic             s_q_full;
    logic             s_q_valid;
    logic             s_q_pop;
    sbld_pkg::t_entry s_push_entry;
    sbld_pkg::t_entry s_q_entry;

    // The front splits each byte into its completed codes.
    sbld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_q_full(s_q_full),
        .o_push  (s_push),
        .o_entry (s_push_entry)
    );

    // The queue lets the front keep taking bytes while the back is stalled.
    sbld_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_push_entry),
        .o_full  (s_q_full),
        .i_pop   (s_q_pop),
        .o_valid (s_q_valid),
        .o_data  (s_q_entry)
    );

    // The back decodes codes one per cycle, while its output is free, into the registered output.
    sbld_back #(
        .MAX_CHARS(MAX_CHARS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(s_q_valid),
        .i_q_entry(s_q_entry),
        .o_q_pop  (s_q_pop),
        .o_out    (o_out)
    );

endmodule

// File: rtl/sbld_checker.sv
module sbld_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [6:0] i_out_char_code,
    input logic       i_out_label_valid,
    input logic       i_out_last
);

    // Only characters carry a code.
    a_code_only_on_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != sbld_pkg::KIND_CHAR) |-> i_out_char_code == 7'd0)
        else $error("char_code nonzero on a separator or end item");

    // Characters never claim a valid label.
    a_lvalid_not_on_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == sbld_pkg::KIND_CHAR) |-> !i_out_label_valid)
        else $error("label_valid set on a character item");

    // Nothing of a byte follows its end of string.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == sbld_pkg::KIND_END) |-> i_out_last)
        else $error("end of string not marked last");

    // A stalled item holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_char_code) && $stable(i_out_label_valid) && $stable(i_out_last))
        else $error("output item changed while stalled");

endmodule

bind six_bit_label_decoder sbld_checker u_sbld_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_kind       (o_out.kind),
    .i_out_char_code  (o_out.char_code),
    .i_out_label_valid(o_out.label_valid),
    .i_out_last       (o_out.last)
);
